/* sv/icy_md_pkg.sv */
// ----------------------------------------------------------------------------
// ICY metadata demultiplexer package
// Shared types and constants for the stream parser and the result queue.
// ----------------------------------------------------------------------------
package icy_md_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned ByteW     = 8;
  localparam int unsigned IntervalW = 24;
  localparam int unsigned MetaLenW  = 12;

  // Interval taken after reset.
  localparam logic [IntervalW-1:0] ResetInterval = 24'd16000;

  // The length byte counts metadata in units of 16 bytes.
  localparam int unsigned MetaUnitShift = 4;

  // Byte value trimmed from the end of a metadata block.
  localparam logic [ByteW-1:0] NulByte = 8'h00;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_AUDIO  = 2'd0,
    PH_LENGTH = 2'd1,
    PH_META   = 2'd2
  } phase_e;

  // Kind tag of a result item.
  typedef enum logic {
    KIND_AUDIO = 1'b0,
    KIND_META  = 1'b1
  } kind_e;

  // One result item as it travels from the parser to the queue.
  typedef struct packed {
    kind_e                kind;
    logic [ByteW-1:0]     data;
    logic                 meta_last;
    logic [MetaLenW-1:0]  meta_length;
  } item_t;

endpackage

/* sv/icy_md_front.sv */
// ----------------------------------------------------------------------------
// ICY metadata demultiplexer front end
// Classifies each incoming byte as audio, length or metadata and builds the
// result item for it; length bytes only reload the counters.
// ----------------------------------------------------------------------------
module icy_md_front import icy_md_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write
  input  logic                 cfg_we_i,
  input  logic [IntervalW-1:0] cfg_data_i,
  // Incoming byte, already qualified by the queue having room
  input  logic                 in_valid_i,
  input  logic [ByteW-1:0]     in_byte_i,
  // Result item towards the queue
  output logic                 out_valid_o,
  output item_t                out_item_o
);

  phase_e               phase_q, phase_d;
  logic [IntervalW-1:0] interval_q, interval_d;
  logic [IntervalW-1:0] audio_rem_q, audio_rem_d;
  logic [MetaLenW-1:0]  meta_rem_q, meta_rem_d;
  logic [MetaLenW-1:0]  meta_cnt_q, meta_cnt_d;
  logic [MetaLenW-1:0]  text_end_q, text_end_d;

  logic                 take_length;
  logic [MetaLenW-1:0]  block_len;
  logic [MetaLenW-1:0]  cnt_inc;
  logic [MetaLenW-1:0]  text_end_upd;
  logic [MetaLenW-1:0]  rem_dec;

  // Block length from the length byte, in bytes.
  assign block_len    = MetaLenW'({in_byte_i, {MetaUnitShift{1'b0}}});
  assign cnt_inc      = meta_cnt_q + MetaLenW'(1);
  assign text_end_upd = (in_byte_i != NulByte) ? cnt_inc : text_end_q;
  assign rem_dec      = meta_rem_q - MetaLenW'(1);

  // Next state and result item.
  always_comb begin
    phase_d     = phase_q;
    interval_d  = interval_q;
    audio_rem_d = audio_rem_q;
    meta_rem_d  = meta_rem_q;
    meta_cnt_d  = meta_cnt_q;
    text_end_d  = text_end_q;
    take_length = 1'b0;
    out_valid_o = 1'b0;
    out_item_o  = '{kind: KIND_AUDIO, data: in_byte_i, meta_last: 1'b0,
                    meta_length: '0};

    if (cfg_we_i) begin
      // A nonzero interval restarts the parser in the audio phase.
      if (cfg_data_i != '0) begin
        interval_d  = cfg_data_i;
        phase_d     = PH_AUDIO;
        audio_rem_d = cfg_data_i;
        meta_rem_d  = '0;
        meta_cnt_d  = '0;
        text_end_d  = '0;
      end
    end else if (in_valid_i) begin
      unique case (phase_q)
        PH_LENGTH: take_length = 1'b1;
        PH_META: begin
          out_valid_o = 1'b1;
          out_item_o.kind = KIND_META;
          meta_rem_d = rem_dec;
          if (rem_dec == '0) begin
            out_item_o.meta_last   = 1'b1;
            out_item_o.meta_length = text_end_upd;
            meta_cnt_d  = '0;
            text_end_d  = '0;
            audio_rem_d = interval_q;
            phase_d     = PH_AUDIO;
          end else begin
            meta_cnt_d = cnt_inc;
            text_end_d = text_end_upd;
          end
        end
        default: begin
          // Audio phase; an exhausted counter means this is the length byte.
          if (audio_rem_q != '0) begin
            out_valid_o = 1'b1;
            audio_rem_d = audio_rem_q - IntervalW'(1);
            phase_d     = (audio_rem_d == '0) ? PH_LENGTH : PH_AUDIO;
          end else begin
            take_length = 1'b1;
          end
        end
      endcase

      // The length byte opens a metadata block or, if zero, skips it.
      if (take_length) begin
        meta_cnt_d = '0;
        text_end_d = '0;
        if (block_len == '0) begin
          meta_rem_d  = '0;
          audio_rem_d = interval_q;
          phase_d     = PH_AUDIO;
        end else begin
          meta_rem_d = block_len;
          phase_d    = PH_META;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_AUDIO;
      interval_q  <= ResetInterval;
      audio_rem_q <= ResetInterval;
      meta_rem_q  <= '0;
      meta_cnt_q  <= '0;
      text_end_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      interval_q  <= interval_d;
      audio_rem_q <= audio_rem_d;
      meta_rem_q  <= meta_rem_d;
      meta_cnt_q  <= meta_cnt_d;
      text_end_q  <= text_end_d;
    end
  end

  // Inside a metadata block there is always at least one byte still to come.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_META |-> meta_rem_q != '0)
    else $error("metadata phase with no bytes remaining");

  // The audio counter never sits at zero in the audio phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_AUDIO |-> audio_rem_q != '0)
    else $error("audio phase with no audio bytes remaining");

  // Only a metadata item can close a block, and its trimmed length fits it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.meta_last |->
      out_item_o.kind == KIND_META && out_item_o.meta_length <= cnt_inc)
    else $error("malformed end of metadata block");

endmodule

/* sv/icy_md_fifo.sv */
// ----------------------------------------------------------------------------
// ICY metadata demultiplexer result queue
// Small first-in first-out queue that decouples the parser from the consumer.
// ----------------------------------------------------------------------------
module icy_md_fifo import icy_md_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_en_i,
  input  item_t wr_item_i,
  output logic  full_o,
  input  logic  rd_en_i,
  output item_t rd_item_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  // Fill level.
  always_comb begin
    count_d = count_q;
    case ({do_wr, do_rd})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

  // The fill level never exceeds the storage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue fill level out of range");

  // The writer is gated by full, so no item is ever dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> !full_o)
    else $error("write to a full queue");

  // Pointers agree with the fill level when the queue is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with an empty queue");

endmodule

/* sv/icy_metadata_demux.sv */
// ----------------------------------------------------------------------------
// ICY metadata demultiplexer
// Splits an ICY stream into tagged audio and metadata items.
// ----------------------------------------------------------------------------
// Latency: an item pushed at one edge is at the result ports from the next
// cycle when no older result waits; a length byte produces no result.
// Throughput: one byte per cycle while the result queue is not full.
// Reset: interval 16000, parser in the audio phase, result queue empty.
module icy_metadata_demux import icy_md_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [IntervalW-1:0] cfg_data_i,
  // Input byte queue side
  input  logic                 push,
  output logic                 full,
  input  logic [ByteW-1:0]     data_byte_i,
  // Result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic                 kind_o,
  output logic [ByteW-1:0]     data_o,
  output logic                 meta_last_o,
  output logic [MetaLenW-1:0]  meta_length_o
);

  logic  front_valid;
  item_t front_item;
  item_t out_item;

  // The register is always writable.
  assign cfg_ready_o = 1'b1;

  // Byte classification.
  icy_md_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (push && !full),
    .in_byte_i   (data_byte_i),
    .out_valid_o (front_valid),
    .out_item_o  (front_item)
  );

  // Result queue.
  icy_md_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (front_valid),
    .wr_item_i (front_item),
    .full_o    (full),
    .rd_en_i   (pop),
    .rd_item_o (out_item),
    .empty_o   (empty)
  );

  assign kind_o        = out_item.kind;
  assign data_o        = out_item.data;
  assign meta_last_o   = out_item.meta_last;
  assign meta_length_o = out_item.meta_length;

endmodule

/* tb/tb_icy_metadata_demux.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ICY metadata demultiplexer testbench
// Feeds byte streams of audio, length bytes and metadata blocks through the
// demultiplexer. The testbench idles and stalls at random on both queue sides,
// predicts each tagged result item and checks it field by field.
// ----------------------------------------------------------------------------
module tb_icy_metadata_demux;
  import icy_md_pkg::*;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned MaxReports  = 40;
  localparam logic [IntervalW-1:0] MaxInterval = '1;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [IntervalW-1:0] cfg_data_i  = '0;
  logic                 push        = 1'b0;
  logic                 full;
  logic [ByteW-1:0]     data_byte_i = '0;
  logic                 empty;
  logic                 pop         = 1'b0;
  logic                 kind_o;
  logic [ByteW-1:0]     data_o;
  logic                 meta_last_o;
  logic [MetaLenW-1:0]  meta_length_o;

  // Shadow copy of the parser state and the interval register.
  phase_e               model_phase;
  logic [IntervalW-1:0] model_interval;
  logic [IntervalW-1:0] audio_todo;
  logic [MetaLenW-1:0]  meta_left;
  logic [MetaLenW-1:0]  meta_seen;
  logic [MetaLenW-1:0]  text_end;

  // Tagged bytes still to come out of the block, oldest first.
  item_t       tagged_bytes_due[$];
  int unsigned error_count = 0;
  int unsigned bytes_sent  = 0;
  int unsigned idle_cycles = 0;

  // Pacing of both sides.
  bit          tx_gaps_on = 1'b1;
  int unsigned tx_calm    = 0;
  int unsigned rx_stall   = 0;
  int unsigned rx_calm    = 0;
  int unsigned hold_asks  = 0;
  int unsigned hold_done  = 0;

  icy_metadata_demux u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .data_o        (data_o),
    .meta_last_o   (meta_last_o),
    .meta_length_o (meta_length_o)
  );

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short idle spells, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(2, 1);
    if (r < 96) return $urandom_range(8, 3);
    return $urandom_range(40, 15);
  endfunction

  // Back to the audio phase with a full interval and cleared block counters.
  function automatic void restart_stream();
    model_phase = PH_AUDIO;
    audio_todo  = model_interval;
    meta_left   = '0;
    meta_seen   = '0;
    text_end    = '0;
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a tagged byte results.
  function automatic bit demux_next(input logic [ByteW-1:0] value, output item_t res_item);
    res_item = '0;
    if (model_phase != PH_LENGTH && model_phase != PH_META) begin
      if (audio_todo != '0) begin
        audio_todo--;
        model_phase    = (audio_todo == '0) ? PH_LENGTH : PH_AUDIO;
        res_item.kind  = KIND_AUDIO;
        res_item.data  = value;
        return 1'b1;
      end
      model_phase = PH_LENGTH;
    end
    if (model_phase == PH_LENGTH) begin
      meta_seen = '0;
      text_end  = '0;
      if (value == '0) begin
        meta_left   = '0;
        audio_todo  = model_interval;
        model_phase = PH_AUDIO;
      end else begin
        meta_left   = MetaLenW'(value) << MetaUnitShift;
        model_phase = PH_META;
      end
      return 1'b0;
    end
    // Metadata byte: track where the text ends before the NUL padding.
    meta_seen++;
    if (value != NulByte) text_end = meta_seen;
    meta_left--;
    res_item.kind = KIND_META;
    res_item.data = value;
    if (meta_left == '0) begin
      res_item.meta_last   = 1'b1;
      res_item.meta_length = text_end;
      meta_seen   = '0;
      text_end    = '0;
      audio_todo  = model_interval;
      model_phase = PH_AUDIO;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Offers one byte after a random gap and waits until it is taken.
  task automatic send_byte(input logic [ByteW-1:0] value);
    int unsigned gap;
    item_t       res_item;
    gap = 0;
    if (tx_gaps_on) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else if ($urandom_range(99) < 3) begin
        tx_calm = $urandom_range(120, 30);
      end else begin
        gap = idle_len();
      end
    end
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= value;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (demux_next(value, res_item)) tagged_bytes_due.push_back(res_item);
    bytes_sent++;
  endtask

  // Writes the interval once the block has drained.
  task automatic set_interval(input logic [IntervalW-1:0] value);
    push <= 1'b0;
    while (tagged_bytes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    // A zero interval is dropped by the block.
    if (value != '0) begin
      model_interval = value;
      restart_stream();
    end
  endtask

  // Rest of the audio run, a length byte and its metadata block. The first
  // text_n block bytes are text and the rest NUL padding, unless noisy.
  task automatic send_frame(input logic [ByteW-1:0] len_byte, input int unsigned text_n,
                            input bit noisy);
    int unsigned audio_n;
    int unsigned block_n;
    audio_n = (model_phase == PH_AUDIO) ? audio_todo : 0;
    block_n = len_byte;
    block_n = block_n << MetaUnitShift;
    repeat (audio_n) send_byte(ByteW'($urandom));
    send_byte(len_byte);
    for (int unsigned i = 0; i < block_n; i++) begin
      if (noisy) begin
        send_byte(ByteW'($urandom));
      end else if (i < text_n) begin
        send_byte(ByteW'($urandom_range(255, 1)));
      end else begin
        send_byte(NulByte);
      end
    end
  endtask

  // Reset interval: the first bytes are all audio.
  task automatic test_reset_interval();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
  endtask

  // Interval of one: a zero length byte, then a block with two text bytes.
  task automatic test_shortest_interval();
    set_interval(IntervalW'(1));
    send_byte(8'h3C);
    send_byte(8'h00);
    send_byte(8'hC3);
    send_frame(8'd1, 2, 1'b0);
  endtask

  // A zero write must leave the interval of one in place.
  task automatic test_zero_write();
    set_interval('0);
    send_frame(8'd0, 0, 1'b0);
    send_byte(8'h81);
  endtask

  // A write in the middle of a metadata block restarts the audio run.
  task automatic test_restart_mid_block();
    set_interval(IntervalW'(3));
    send_byte(8'h11);
    send_byte(8'h22);
    set_interval(IntervalW'(2));
    send_byte(8'h33);
    send_byte(8'h44);
    send_byte(8'h01);
    repeat (5) send_byte(8'h41);
    set_interval(IntervalW'(4));
    send_frame(8'd0, 0, 1'b0);
  endtask

  // Largest interval: only the first few audio bytes are sent.
  task automatic test_max_interval();
    set_interval(MaxInterval);
    repeat (4) send_byte(ByteW'($urandom));
  endtask

  // A long block, all text, so the reported length is the full block.
  task automatic test_longest_block();
    set_interval(IntervalW'(2));
    send_frame(8'h30, 768, 1'b0);
    send_frame(8'd1, 16, 1'b0);
  endtask

  // The receiver holds off while the sender keeps pushing, so the result queue fills.
  task automatic test_input_stall();
    set_interval(IntervalW'(5));
    tx_gaps_on = 1'b0;
    hold_asks <= hold_asks + 1;
    repeat (8) send_frame(8'd1, $urandom_range(16), 1'b0);
    tx_gaps_on = 1'b1;
  endtask

  // Random intervals and well-formed frames with random content and padding.
  task automatic test_random_stream();
    int unsigned first;
    int unsigned r;
    logic [IntervalW-1:0] interval;
    logic [ByteW-1:0]     len_byte;
    int unsigned          text_n;
    first = bytes_sent;
    while (bytes_sent - first < RandomItems) begin
      r = $urandom_range(99);
      if (r < 20) interval = IntervalW'(1);
      else if (r < 35) interval = IntervalW'(2);
      else if (r < 95) interval = IntervalW'($urandom_range(40, 3));
      else interval = IntervalW'($urandom_range(300, 100));
      set_interval(interval);
      repeat ($urandom_range(6, 2)) begin
        r = $urandom_range(99);
        if (r < 35) len_byte = 8'd0;
        else if (r < 80) len_byte = 8'd1;
        else if (r < 93) len_byte = 8'd2;
        else len_byte = ByteW'($urandom_range(6, 3));
        r = $urandom_range(99);
        if (r < 20) text_n = 0;
        else if (r < 35) text_n = 4080;
        else text_n = $urandom_range(int'(len_byte) * 16);
        send_frame(len_byte, text_n, $urandom_range(99) < 15);
      end
    end
  endtask

  // Checks each taken result item and paces the receiver.
  always @(posedge clk_i) begin
    item_t due;
    if (rst_ni && pop && !empty) begin
      if (tagged_bytes_due.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports) begin
          $display("%0t: unexpected result item, kind %0d data %0d", $time, kind_o, data_o);
        end
      end else begin
        due = tagged_bytes_due.pop_front();
        if (kind_o !== due.kind) report_mismatch("kind", due.kind, kind_o);
        if (data_o !== due.data) report_mismatch("data", due.data, data_o);
        if (meta_last_o !== due.meta_last) begin
          report_mismatch("meta_last", due.meta_last, meta_last_o);
        end
        if (meta_length_o !== due.meta_length) begin
          report_mismatch("meta_length", due.meta_length, meta_length_o);
        end
      end
    end
    // A requested hold-off takes priority over the random pacing.
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      rx_stall  = LongHold;
      rx_calm   = 0;
    end
    if (rx_stall > 0) begin
      rx_stall--;
      pop <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm--;
      pop <= 1'b1;
    end else if ($urandom_range(99) < 3) begin
      rx_calm = $urandom_range(120, 30);
      pop <= 1'b1;
    end else begin
      rx_stall = idle_len();
      if (rx_stall == 0) begin
        pop <= 1'b1;
      end else begin
        rx_stall--;
        pop <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no handshake completes for too long.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    model_interval = ResetInterval;
    restart_stream();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_interval();
    test_shortest_interval();
    test_zero_write();
    test_restart_mid_block();
    test_max_interval();
    test_longest_block();
    test_input_stall();
    test_random_stream();
    // Drain, then give the block time to show any stray item.
    push <= 1'b0;
    while (tagged_bytes_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* icy_metadata_demux.f */
sv/icy_md_pkg.sv
sv/icy_md_front.sv
sv/icy_md_fifo.sv
sv/icy_metadata_demux.sv
tb/tb_icy_metadata_demux.sv
